>>> src/mvna_pkg.sv
// shared types and constants for the mesh vertex normal accumulator
// no dependencies; used by mvna_ctrl, mvna_dp and the top level
package mvna_pkg;

    localparam int VTX_COUNT   = 1024;
    localparam int IDX_W       = 10;
    localparam int COORD_W     = 32;
    localparam int SUM_W       = 24;
    localparam int NORM_W      = 16;
    localparam int UNIT_SHIFT  = 14;
    localparam int EDGE_W      = COORD_W + 1;
    localparam int FIT_BITS    = 30;
    localparam int MUL_W       = FIT_BITS + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int SQ_W        = 62;
    localparam int ROOT_W      = 63;
    localparam int LEN_W       = 31;
    localparam int REM_W       = 46;
    localparam int QUO_W       = UNIT_SHIFT + 1;
    localparam int CNT_W       = 5;
    localparam int CROSS_STEPS = 7;
    localparam int SQ_STEPS    = 4;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = QUO_W;
    localparam logic [1:0] LAST_SEL = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_code_t;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_VRD,
        DP_VA,
        DP_EB,
        DP_EC,
        DP_EFIT,
        DP_CROSS,
        DP_SUMRD,
        DP_SUMLD,
        DP_MAG,
        DP_NSHIFT,
        DP_SQ,
        DP_SQRT_INIT,
        DP_SQRT,
        DP_DIV_INIT,
        DP_DIV,
        DP_DIV_END,
        DP_ACC_RD,
        DP_ACC_WR
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_VRD,
        ST_VA,
        ST_EB,
        ST_EC,
        ST_EFIT,
        ST_CROSS,
        ST_SUMRD,
        ST_SUMLD,
        ST_MAG,
        ST_NFIT,
        ST_SQ,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] step;
        logic [1:0] sel;
        logic       capture;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic fits;
    } dp_status_t;

endpackage

>>> src/mvna_ctrl.sv
// controller state machine: sequences loads, triangles and reads
// depends on mvna_pkg; drives mvna_dp through dp_cmd_t
module mvna_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [1:0]           operation,
    output logic                 result_valid,
    input  logic                 result_stall,
    output mvna_pkg::dp_cmd_t    cmd,
    input  mvna_pkg::dp_status_t status
);

    mvna_pkg::ctrl_state_t          state_reg, state_next;
    logic [mvna_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]                     sel_reg, sel_next;
    logic                           tri_reg, tri_next;
    logic                           valid_reg, valid_next;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvna_pkg::ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= '0;
            tri_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            tri_reg   <= tri_next;
            valid_reg <= valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        tri_next     = tri_reg;
        cmd          = '0;
        cmd.op       = mvna_pkg::DP_IDLE;
        cmd.step     = cnt_reg[2:0];
        cmd.sel      = sel_reg;
        case (state_reg)
            mvna_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    sel_next    = '0;
                    case (operation)
                        mvna_pkg::OP_LOAD: state_next = mvna_pkg::ST_LOAD;
                        mvna_pkg::OP_TRI:
                        begin
                            state_next = mvna_pkg::ST_VRD;
                            tri_next   = 1'b1;
                        end
                        mvna_pkg::OP_READ:
                        begin
                            state_next = mvna_pkg::ST_SUMRD;
                            tri_next   = 1'b0;
                        end
                        default: state_next = mvna_pkg::ST_IDLE;
                    endcase
                end
            end
            mvna_pkg::ST_LOAD:
            begin
                cmd.op     = mvna_pkg::DP_LOAD;
                state_next = mvna_pkg::ST_IDLE;
            end
            mvna_pkg::ST_VRD:
            begin
                cmd.op     = mvna_pkg::DP_VRD;
                state_next = mvna_pkg::ST_VA;
            end
            mvna_pkg::ST_VA:
            begin
                cmd.op     = mvna_pkg::DP_VA;
                state_next = mvna_pkg::ST_EB;
            end
            mvna_pkg::ST_EB:
            begin
                cmd.op     = mvna_pkg::DP_EB;
                state_next = mvna_pkg::ST_EC;
            end
            mvna_pkg::ST_EC:
            begin
                cmd.op     = mvna_pkg::DP_EC;
                state_next = mvna_pkg::ST_EFIT;
            end
            mvna_pkg::ST_EFIT:
            begin
                cmd.op     = mvna_pkg::DP_EFIT;
                cnt_next   = '0;
                state_next = mvna_pkg::ST_CROSS;
            end
            mvna_pkg::ST_CROSS:
            begin
                cmd.op = mvna_pkg::DP_CROSS;
                if (cnt_reg == mvna_pkg::CNT_W'(mvna_pkg::CROSS_STEPS - 1))
                    state_next = mvna_pkg::ST_MAG;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            mvna_pkg::ST_SUMRD:
            begin
                cmd.op     = mvna_pkg::DP_SUMRD;
                state_next = mvna_pkg::ST_SUMLD;
            end
            mvna_pkg::ST_SUMLD:
            begin
                cmd.op     = mvna_pkg::DP_SUMLD;
                state_next = mvna_pkg::ST_MAG;
            end
            mvna_pkg::ST_MAG:
            begin
                cmd.op     = mvna_pkg::DP_MAG;
                state_next = mvna_pkg::ST_NFIT;
            end
            mvna_pkg::ST_NFIT:
            begin
                if (status.fits)
                begin
                    cnt_next   = '0;
                    state_next = mvna_pkg::ST_SQ;
                end
                else
                    cmd.op = mvna_pkg::DP_NSHIFT;
            end
            mvna_pkg::ST_SQ:
            begin
                cmd.op = mvna_pkg::DP_SQ;
                if (cnt_reg == mvna_pkg::CNT_W'(mvna_pkg::SQ_STEPS - 1))
                    state_next = mvna_pkg::ST_SQRT_INIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            mvna_pkg::ST_SQRT_INIT:
            begin
                cmd.op     = mvna_pkg::DP_SQRT_INIT;
                cnt_next   = '0;
                state_next = mvna_pkg::ST_SQRT;
            end
            mvna_pkg::ST_SQRT:
            begin
                cmd.op = mvna_pkg::DP_SQRT;
                if (cnt_reg == mvna_pkg::CNT_W'(mvna_pkg::SQRT_STEPS - 1))
                begin
                    sel_next   = '0;
                    state_next = mvna_pkg::ST_DIV_INIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            mvna_pkg::ST_DIV_INIT:
            begin
                cmd.op     = mvna_pkg::DP_DIV_INIT;
                cnt_next   = '0;
                state_next = mvna_pkg::ST_DIV;
            end
            mvna_pkg::ST_DIV:
            begin
                cmd.op = mvna_pkg::DP_DIV;
                if (cnt_reg == mvna_pkg::CNT_W'(mvna_pkg::DIV_STEPS - 1))
                    state_next = mvna_pkg::ST_DIV_END;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            mvna_pkg::ST_DIV_END:
            begin
                cmd.op = mvna_pkg::DP_DIV_END;
                if (sel_reg == mvna_pkg::LAST_SEL)
                begin
                    sel_next   = '0;
                    state_next = tri_reg ? mvna_pkg::ST_ACC_RD : mvna_pkg::ST_OUT;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = mvna_pkg::ST_DIV_INIT;
                end
            end
            mvna_pkg::ST_ACC_RD:
            begin
                cmd.op     = mvna_pkg::DP_ACC_RD;
                state_next = mvna_pkg::ST_ACC_WR;
            end
            mvna_pkg::ST_ACC_WR:
            begin
                cmd.op = mvna_pkg::DP_ACC_WR;
                if (sel_reg == mvna_pkg::LAST_SEL)
                    state_next = mvna_pkg::ST_IDLE;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = mvna_pkg::ST_ACC_RD;
                end
            end
            mvna_pkg::ST_OUT:
            begin
                if (!valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mvna_pkg::ST_IDLE;
                end
            end
            default: state_next = mvna_pkg::ST_IDLE;
        endcase
        valid_next = cmd.out_load | (valid_reg & result_stall);
    end

    assign item_stall   = (state_reg != mvna_pkg::ST_IDLE);
    assign result_valid = valid_reg;

    // checks
    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == mvna_pkg::ST_OUT))
        else $error("result valid rose outside output state");
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg != 2'd3)
        else $error("component select out of range");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mvna_pkg::ST_DIV |->
            cnt_reg <= mvna_pkg::CNT_W'(mvna_pkg::DIV_STEPS - 1))
        else $error("divide step count overrun");
    a_busy_after_tri: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && operation == mvna_pkg::OP_TRI |=> item_stall)
        else $error("triangle transaction did not make block busy");

endmodule

>>> src/mvna_dp.sv
// datapath: vertex and normal-sum memories, shared multiplier,
// bitwise square root and restoring divider; depends on mvna_pkg
module mvna_dp (
    input  logic                                 clk,
    input  mvna_pkg::dp_cmd_t                    cmd,
    output mvna_pkg::dp_status_t                 status,
    input  logic [mvna_pkg::IDX_W-1:0]           index_a,
    input  logic [mvna_pkg::IDX_W-1:0]           index_b,
    input  logic [mvna_pkg::IDX_W-1:0]           index_c,
    input  logic signed [mvna_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [mvna_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [mvna_pkg::COORD_W-1:0]  coord_z,
    output logic [mvna_pkg::IDX_W-1:0]           read_index,
    output logic signed [mvna_pkg::NORM_W-1:0]   normal_x,
    output logic signed [mvna_pkg::NORM_W-1:0]   normal_y,
    output logic signed [mvna_pkg::NORM_W-1:0]   normal_z
);

    localparam int CW = mvna_pkg::COORD_W;
    localparam int SW = mvna_pkg::SUM_W;
    localparam int EW = mvna_pkg::EDGE_W;
    localparam int MW = mvna_pkg::MAG_W;
    localparam int PW = mvna_pkg::PROD_W;
    localparam int NW = mvna_pkg::NORM_W;
    localparam int FB = mvna_pkg::FIT_BITS;

    // memories
    logic signed [CW-1:0] vx_mem [mvna_pkg::VTX_COUNT];
    logic signed [CW-1:0] vy_mem [mvna_pkg::VTX_COUNT];
    logic signed [CW-1:0] vz_mem [mvna_pkg::VTX_COUNT];
    logic signed [SW-1:0] sx_mem [mvna_pkg::VTX_COUNT];
    logic signed [SW-1:0] sy_mem [mvna_pkg::VTX_COUNT];
    logic signed [SW-1:0] sz_mem [mvna_pkg::VTX_COUNT];
    logic signed [CW-1:0] vx_q, vy_q, vz_q;
    logic signed [SW-1:0] sx_q, sy_q, sz_q;

    logic [mvna_pkg::IDX_W-1:0] a_reg, b_reg, c_reg;
    logic signed [CW-1:0]       cx_reg, cy_reg, cz_reg;
    logic signed [CW-1:0]       va_reg [3];
    logic signed [EW-1:0]       e_reg [6];
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       cr_reg [3];
    logic                       ns_reg [3];
    logic [MW-1:0]              nm_reg [3];
    logic [mvna_pkg::SQ_W-1:0]  sq_reg, rn_reg;
    logic [mvna_pkg::ROOT_W-1:0] root_reg, bit_reg;
    logic [mvna_pkg::REM_W-1:0] rem_reg, den_reg;
    logic [mvna_pkg::QUO_W-1:0] quo_reg;
    logic signed [NW-1:0]       nv_reg [3];
    logic [mvna_pkg::IDX_W-1:0] rdi_reg;
    logic signed [NW-1:0]       ox_reg, oy_reg, oz_reg;

    logic [mvna_pkg::IDX_W-1:0] v_addr, s_addr, corner;
    logic                       v_we, s_we;
    logic signed [SW-1:0]       wx, wy, wz;
    logic [EW-1:0]              emag [6];
    logic [EW-1:0]              eor;
    logic [EW-1:0]              efit [6];
    logic signed [mvna_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]       mul_p;
    logic [mvna_pkg::ROOT_W:0]  sq_t;
    logic [mvna_pkg::LEN_W-1:0] len;
    logic                       div_ge;
    logic signed [NW-1:0]       qs;

    // addresses and write enables
    always_comb
    begin
        case (cmd.sel)
            2'd0:    corner = a_reg;
            2'd1:    corner = b_reg;
            default: corner = c_reg;
        endcase
        case (cmd.op)
            mvna_pkg::DP_VA: v_addr = b_reg;
            mvna_pkg::DP_EB: v_addr = c_reg;
            default:         v_addr = a_reg;
        endcase
        s_addr = (cmd.op == mvna_pkg::DP_ACC_WR || cmd.op == mvna_pkg::DP_ACC_RD)
                 ? corner : a_reg;
        v_we   = (cmd.op == mvna_pkg::DP_LOAD);
        s_we   = v_we || (cmd.op == mvna_pkg::DP_ACC_WR);
    end

    // saturating add of the face normal into the sums
    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] acc,
                                                    input logic signed [NW-1:0] d);
        logic signed [SW:0] s;
        s = {acc[SW-1], acc} + (SW+1)'(d);
        if (s[SW] != s[SW-1])
            sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        else
            sat_add = s[SW-1:0];
    endfunction

    always_comb
    begin
        wx = v_we ? '0 : sat_add(sx_q, nv_reg[0]);
        wy = v_we ? '0 : sat_add(sy_q, nv_reg[1]);
        wz = v_we ? '0 : sat_add(sz_q, nv_reg[2]);
    end

    // vertex coordinate memories
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vx_mem[a_reg] <= cx_reg;
            vy_mem[a_reg] <= cy_reg;
            vz_mem[a_reg] <= cz_reg;
        end
        vx_q <= vx_mem[v_addr];
        vy_q <= vy_mem[v_addr];
        vz_q <= vz_mem[v_addr];
    end

    // normal sum memories
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            sx_mem[s_addr] <= wx;
            sy_mem[s_addr] <= wy;
            sz_mem[s_addr] <= wz;
        end
        sx_q <= sx_mem[s_addr];
        sy_q <= sy_mem[s_addr];
        sz_q <= sz_mem[s_addr];
    end

    // common scaling of the edge components of b-a and c-a
    always_comb
    begin
        eor = '0;
        for (int i = 0; i < 6; i++)
        begin
            emag[i] = e_reg[i][EW-1] ? EW'(-e_reg[i]) : EW'(e_reg[i]);
            eor     = eor | emag[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            if (eor[EW-1])
                efit[i] = emag[i] >> 3;
            else if (eor[EW-2])
                efit[i] = emag[i] >> 2;
            else if (eor[EW-3])
                efit[i] = emag[i] >> 1;
            else
                efit[i] = emag[i];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == mvna_pkg::DP_CROSS)
        begin
            case (cmd.step)
                3'd0:
                begin
                    mul_a = e_reg[1][mvna_pkg::MUL_W-1:0];
                    mul_b = e_reg[5][mvna_pkg::MUL_W-1:0];
                end
                3'd1:
                begin
                    mul_a = e_reg[2][mvna_pkg::MUL_W-1:0];
                    mul_b = e_reg[4][mvna_pkg::MUL_W-1:0];
                end
                3'd2:
                begin
                    mul_a = e_reg[2][mvna_pkg::MUL_W-1:0];
                    mul_b = e_reg[3][mvna_pkg::MUL_W-1:0];
                end
                3'd3:
                begin
                    mul_a = e_reg[0][mvna_pkg::MUL_W-1:0];
                    mul_b = e_reg[5][mvna_pkg::MUL_W-1:0];
                end
                3'd4:
                begin
                    mul_a = e_reg[0][mvna_pkg::MUL_W-1:0];
                    mul_b = e_reg[4][mvna_pkg::MUL_W-1:0];
                end
                3'd5:
                begin
                    mul_a = e_reg[1][mvna_pkg::MUL_W-1:0];
                    mul_b = e_reg[3][mvna_pkg::MUL_W-1:0];
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (cmd.op == mvna_pkg::DP_SQ && cmd.step < 3'd3)
        begin
            mul_a = {1'b0, nm_reg[cmd.step[1:0]][FB-1:0]};
            mul_b = mul_a;
        end
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // square root step, divider step and status
    always_comb
    begin
        sq_t   = {1'b0, root_reg} + {1'b0, bit_reg};
        len    = root_reg[mvna_pkg::LEN_W-1:0];
        div_ge = (rem_reg >= den_reg);
        qs     = NW'(quo_reg);
        status.fits = ~|(nm_reg[0][MW-1:FB] | nm_reg[1][MW-1:FB] | nm_reg[2][MW-1:FB]);
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (cmd.capture)
        begin
            a_reg  <= index_a;
            b_reg  <= index_b;
            c_reg  <= index_c;
            cx_reg <= coord_x;
            cy_reg <= coord_y;
            cz_reg <= coord_z;
        end
        case (cmd.op)
            mvna_pkg::DP_VA:
            begin
                va_reg[0] <= vx_q;
                va_reg[1] <= vy_q;
                va_reg[2] <= vz_q;
            end
            mvna_pkg::DP_EB:
            begin
                e_reg[0] <= EW'(vx_q) - EW'(va_reg[0]);
                e_reg[1] <= EW'(vy_q) - EW'(va_reg[1]);
                e_reg[2] <= EW'(vz_q) - EW'(va_reg[2]);
            end
            mvna_pkg::DP_EC:
            begin
                e_reg[3] <= EW'(vx_q) - EW'(va_reg[0]);
                e_reg[4] <= EW'(vy_q) - EW'(va_reg[1]);
                e_reg[5] <= EW'(vz_q) - EW'(va_reg[2]);
            end
            mvna_pkg::DP_EFIT:
            begin
                for (int i = 0; i < 6; i++)
                    e_reg[i] <= e_reg[i][EW-1] ? -$signed(efit[i]) : $signed(efit[i]);
            end
            mvna_pkg::DP_CROSS:
            begin
                // product of the previous step lands in its component
                case (cmd.step)
                    3'd1: cr_reg[0] <= prod_reg;
                    3'd2: cr_reg[0] <= cr_reg[0] - prod_reg;
                    3'd3: cr_reg[1] <= prod_reg;
                    3'd4: cr_reg[1] <= cr_reg[1] - prod_reg;
                    3'd5: cr_reg[2] <= prod_reg;
                    3'd6: cr_reg[2] <= cr_reg[2] - prod_reg;
                    default: ;
                endcase
            end
            mvna_pkg::DP_SUMLD:
            begin
                cr_reg[0] <= PW'(sx_q);
                cr_reg[1] <= PW'(sy_q);
                cr_reg[2] <= PW'(sz_q);
            end
            mvna_pkg::DP_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ns_reg[i] <= cr_reg[i][PW-1];
                    nm_reg[i] <= cr_reg[i][PW-1] ? MW'(-cr_reg[i]) : MW'(cr_reg[i]);
                end
            end
            mvna_pkg::DP_NSHIFT:
            begin
                for (int i = 0; i < 3; i++)
                    nm_reg[i] <= nm_reg[i] >> 1;
            end
            mvna_pkg::DP_SQ:
            begin
                if (cmd.step == 3'd1)
                    sq_reg <= prod_reg[mvna_pkg::SQ_W-1:0];
                else if (cmd.step != 3'd0)
                    sq_reg <= sq_reg + prod_reg[mvna_pkg::SQ_W-1:0];
            end
            mvna_pkg::DP_SQRT_INIT:
            begin
                rn_reg   <= sq_reg;
                root_reg <= '0;
                bit_reg  <= {1'b1, {(mvna_pkg::ROOT_W-1){1'b0}}};
            end
            mvna_pkg::DP_SQRT:
            begin
                if ({2'b00, rn_reg} >= sq_t)
                begin
                    rn_reg   <= rn_reg - sq_t[mvna_pkg::SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            mvna_pkg::DP_DIV_INIT:
            begin
                rem_reg <= {2'b00, nm_reg[cmd.sel][FB-1:0], {mvna_pkg::UNIT_SHIFT{1'b0}}}
                         + mvna_pkg::REM_W'(len[mvna_pkg::LEN_W-1:1]);
                den_reg <= {1'b0, len, {mvna_pkg::UNIT_SHIFT{1'b0}}};
                quo_reg <= '0;
            end
            mvna_pkg::DP_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_reg - den_reg;
                quo_reg <= {quo_reg[mvna_pkg::QUO_W-2:0], div_ge};
                den_reg <= den_reg >> 1;
            end
            mvna_pkg::DP_DIV_END:
            begin
                if (len == '0)
                    nv_reg[cmd.sel] <= '0;
                else
                    nv_reg[cmd.sel] <= ns_reg[cmd.sel] ? -qs : qs;
            end
            default: ;
        endcase
        // output register
        if (cmd.out_load)
        begin
            rdi_reg <= a_reg;
            ox_reg  <= nv_reg[0];
            oy_reg  <= nv_reg[1];
            oz_reg  <= nv_reg[2];
        end
    end

    assign read_index = rdi_reg;
    assign normal_x   = ox_reg;
    assign normal_y   = oy_reg;
    assign normal_z   = oz_reg;

endmodule

>>> src/mesh_vertex_normal_accumulator.sv
// Smooth vertex normal accumulator, one transaction at a time. The run time of
// a triangle or a read varies with the one-bit-per-cycle scaling of its normal
// vector, the cross product or the stored sum. The work is done by the
// 32-step bitwise square root, three 15-step restoring divisions and one
// shared 31x31 multiplier, all on a single datapath. A read
// result waits in an output register while the next transaction is taken.
// Every vertex must be loaded before a triangle or read uses it.
// depends on mvna_pkg, mvna_ctrl and mvna_dp
module mesh_vertex_normal_accumulator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [1:0]                           operation,
    input  logic [mvna_pkg::IDX_W-1:0]           index_a,
    input  logic [mvna_pkg::IDX_W-1:0]           index_b,
    input  logic [mvna_pkg::IDX_W-1:0]           index_c,
    input  logic signed [mvna_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [mvna_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [mvna_pkg::COORD_W-1:0]  coord_z,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [mvna_pkg::IDX_W-1:0]           read_index,
    output logic signed [mvna_pkg::NORM_W-1:0]   normal_x,
    output logic signed [mvna_pkg::NORM_W-1:0]   normal_y,
    output logic signed [mvna_pkg::NORM_W-1:0]   normal_z
);

    mvna_pkg::dp_cmd_t    cmd;
    mvna_pkg::dp_status_t status;

    // sequencer
    mvna_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // arithmetic and storage
    mvna_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .index_a    (index_a),
        .index_b    (index_b),
        .index_c    (index_c),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .read_index (read_index),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z)
    );

endmodule

>>> dv/mvna_checker.sv
// transaction checker for the mesh vertex normal accumulator: predicts reads and compares
// depends on mvna_pkg for widths and operation codes
`timescale 1ns / 100ps

module mvna_checker
    import mvna_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_stall,
    input  logic [1:0]                operation,
    input  logic [IDX_W-1:0]          index_a,
    input  logic [IDX_W-1:0]          index_b,
    input  logic [IDX_W-1:0]          index_c,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic [IDX_W-1:0]          read_index,
    input  logic signed [NORM_W-1:0]  normal_x,
    input  logic signed [NORM_W-1:0]  normal_y,
    input  logic signed [NORM_W-1:0]  normal_z,
    output int                        fail_count,
    output int                        pending_count,
    output int                        read_count
);

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } vertex_normal_t;

    // mirror of the vertex and accumulator stores
    int     pos_x [VTX_COUNT];
    int     pos_y [VTX_COUNT];
    int     pos_z [VTX_COUNT];
    longint acc_x [VTX_COUNT];
    longint acc_y [VTX_COUNT];
    longint acc_z [VTX_COUNT];

    vertex_normal_t pending_normals [$];

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // smallest right shift that brings the largest magnitude below 2^30
    function automatic int fit_shift(input longint unsigned m);
        int s;
        s = 0;
        while ((m >> s) >= (64'd1 << FIT_BITS))
            s++;
        return s;
    endfunction

    function automatic longint shrink(input longint v, input int s);
        longint unsigned a;
        a = magnitude(v) >> s;
        return (v < 0) ? -longint'(a) : longint'(a);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= r + bitv)
            begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_component(input longint v, input longint unsigned len);
        longint unsigned q;
        if (len == 0)
            return 0;
        q = (magnitude(v) * (64'd1 << UNIT_SHIFT) + len / 2) / len;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic normalize(input longint ix, input longint iy, input longint iz,
                             output longint ox, output longint oy, output longint oz);
        longint unsigned m;
        longint unsigned len;
        int s;
        m = magnitude(ix);
        if (magnitude(iy) > m) m = magnitude(iy);
        if (magnitude(iz) > m) m = magnitude(iz);
        s = fit_shift(m);
        ix = shrink(ix, s);
        iy = shrink(iy, s);
        iz = shrink(iz, s);
        len = int_sqrt(magnitude(ix) * magnitude(ix) + magnitude(iy) * magnitude(iy)
                       + magnitude(iz) * magnitude(iz));
        ox = unit_component(ix, len);
        oy = unit_component(iy, len);
        oz = unit_component(iz, len);
    endtask

    function automatic longint sat_sum(input longint acc, input longint d);
        longint lim;
        longint r;
        lim = longint'(1) << (SUM_W - 1);
        r = acc + d;
        if (r > lim - 1) r = lim - 1;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    task automatic accumulate(input int k, input longint nx, input longint ny,
                              input longint nz);
        acc_x[k] = sat_sum(acc_x[k], nx);
        acc_y[k] = sat_sum(acc_y[k], ny);
        acc_z[k] = sat_sum(acc_z[k], nz);
    endtask

    // face normal from edges b-a and c-a, added to all three corners
    task automatic add_face(input int a, input int b, input int c);
        longint e [6];
        longint unsigned m;
        longint cx, cy, cz, nx, ny, nz;
        int s;
        e[0] = longint'(pos_x[b]) - pos_x[a];
        e[1] = longint'(pos_y[b]) - pos_y[a];
        e[2] = longint'(pos_z[b]) - pos_z[a];
        e[3] = longint'(pos_x[c]) - pos_x[a];
        e[4] = longint'(pos_y[c]) - pos_y[a];
        e[5] = longint'(pos_z[c]) - pos_z[a];
        m = 0;
        for (int i = 0; i < 6; i++)
            if (magnitude(e[i]) > m) m = magnitude(e[i]);
        s = fit_shift(m);
        for (int i = 0; i < 6; i++)
            e[i] = shrink(e[i], s);
        cx = e[1] * e[5] - e[2] * e[4];
        cy = e[2] * e[3] - e[0] * e[5];
        cz = e[0] * e[4] - e[1] * e[3];
        normalize(cx, cy, cz, nx, ny, nz);
        accumulate(a, nx, ny, nz);
        accumulate(b, nx, ny, nz);
        accumulate(c, nx, ny, nz);
    endtask

    assign pending_count = pending_normals.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            read_count <= 0;
            pending_normals.delete();
            for (int i = 0; i < VTX_COUNT; i++)
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
            end
        end
        else
        begin
            vertex_normal_t want;
            vertex_normal_t got;
            longint nx, ny, nz;
            // result side: compare against the oldest predicted read
            if (result_valid && !result_stall)
            begin
                read_count <= read_count + 1;
                if (pending_normals.size() == 0)
                begin
                    $display("%0t: unexpected result, read_index %0d", $time, read_index);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pending_normals.pop_front();
                    got.idx = read_index;
                    got.nx = normal_x;
                    got.ny = normal_y;
                    got.nz = normal_z;
                    if (got.idx !== want.idx || got.nx !== want.nx || got.ny !== want.ny
                        || got.nz !== want.nz)
                    begin
                        $display({"%0t: mismatch expected idx %0d n (%0d %0d %0d)",
                                  " actual idx %0d n (%0d %0d %0d)"},
                                 $time, want.idx, want.nx, want.ny, want.nz,
                                 got.idx, got.nx, got.ny, got.nz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // item side: update the mirrored state
            if (item_valid && !item_stall)
            begin
                case (operation)
                    OP_LOAD:
                    begin
                        pos_x[index_a] = coord_x;
                        pos_y[index_a] = coord_y;
                        pos_z[index_a] = coord_z;
                        acc_x[index_a] = 0;
                        acc_y[index_a] = 0;
                        acc_z[index_a] = 0;
                    end
                    OP_TRI:
                        add_face(index_a, index_b, index_c);
                    OP_READ:
                    begin
                        normalize(acc_x[index_a], acc_y[index_a], acc_z[index_a], nx, ny, nz);
                        want.idx = index_a;
                        want.nx = nx[NORM_W-1:0];
                        want.ny = ny[NORM_W-1:0];
                        want.nz = nz[NORM_W-1:0];
                        pending_normals.insert(pending_normals.size(), want);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> dv/mesh_vertex_normal_accumulator_tb.sv
// stimulus and verdict for the mesh vertex normal accumulator
// depends on mvna_pkg, mvna_checker and the block itself
`timescale 1ns / 100ps

module mesh_vertex_normal_accumulator_tb;
    import mvna_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_stall;
    logic [1:0]                operation;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      result_valid;
    logic                      result_stall;
    logic [IDX_W-1:0]          read_index;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    int                        fail_count;
    int                        pending_count;
    int                        read_count;

    bit quiet;
    bit loaded [VTX_COUNT];
    int loaded_list [$];
    int tri_count;
    int load_count;
    int stall_left;

    mesh_vertex_normal_accumulator u_dut (.*);

    mvna_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stall bursts, started at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else if (quiet)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 17);
        end
        else
            result_stall <= 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("mesh_vertex_normal_accumulator verification failed");
        $finish;
    end

    // drive one transaction and return at the edge that accepts it, or after an idle burst
    task automatic send(input op_code_t op, input int a, input int b, input int c,
                        input int x, input int y, input int z);
        bit taken;
        operation  <= op;
        index_a    <= a[IDX_W-1:0];
        index_b    <= b[IDX_W-1:0];
        index_c    <= c[IDX_W-1:0];
        coord_x    <= x;
        coord_y    <= y;
        coord_z    <= z;
        item_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        while (!taken);
        if (op == OP_LOAD)
        begin
            load_count++;
            if (!loaded[a])
                loaded_list.insert(loaded_list.size(), a);
            loaded[a] = 1'b1;
        end
        if (op == OP_TRI)
            tri_count++;
        // sender idle burst
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return int'($urandom);
            1: return ($urandom_range(0, 4000) - 2000) <<< 16;
            2: return $urandom_range(0, 200000) - 100000;
            default: return ($urandom_range(0, 64) - 32) <<< 24;
        endcase
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial
    begin
        int a, b, c;
        int sel;
        quiet = 1'b0;
        item_valid = 1'b0;
        operation = OP_NONE;
        index_a = '0;
        index_b = '0;
        index_c = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: coordinate extremes, degenerate and repeated corners, fresh reads
        send(OP_LOAD, 0, 0, 0, 0, 0, 0);
        send(OP_LOAD, 1, 0, 0, 32'h7fffffff, 0, 0);
        send(OP_LOAD, 2, 0, 0, 0, 32'h80000000, 0);
        send(OP_LOAD, 3, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
        send(OP_LOAD, 4, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send(OP_LOAD, 1023, 0, 0, 1 << 16, 0, 0);
        send(OP_LOAD, 512, 0, 0, 0, 1 << 16, 0);
        send(OP_READ, 1023, 0, 0, 0, 0, 0);
        send(OP_TRI, 0, 1, 2, 0, 0, 0);
        send(OP_TRI, 3, 4, 1, 0, 0, 0);
        send(OP_TRI, 0, 1023, 512, 0, 0, 0);
        send(OP_TRI, 0, 0, 1, 0, 0, 0);
        send(OP_TRI, 1, 2, 1, 0, 0, 0);
        send(OP_TRI, 4, 0, 3, 0, 0, 0);
        send(OP_NONE, 5, 6, 7, -1, -1, -1);
        send(OP_READ, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 1, 0, 0, 0, 0, 0);
        send(OP_READ, 2, 0, 0, 0, 0, 0);
        send(OP_READ, 3, 0, 0, 0, 0, 0);
        send(OP_READ, 4, 0, 0, 0, 0, 0);
        send(OP_READ, 1023, 0, 0, 0, 0, 0);
        send(OP_READ, 512, 0, 0, 0, 0, 0);

        // random mesh: a batch of loads, then mostly triangles and reads
        repeat (60)
            send(OP_LOAD, $urandom_range(0, 1023), 0, 0, rand_coord(), rand_coord(),
                 rand_coord());
        for (int i = 0; i < 700; i++)
        begin
            if (i == 350)
            begin
                // hold off until every outstanding read has come back
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0) @(posedge clk);
            end
            sel = $urandom_range(0, 99);
            a = pick_loaded();
            b = pick_loaded();
            c = pick_loaded();
            if (sel < 8)
                send(OP_LOAD, (sel < 4) ? $urandom_range(0, 1023) : a, 0, 0, rand_coord(),
                     rand_coord(), rand_coord());
            else if (sel < 60)
                send(OP_TRI, a, (sel < 14) ? a : b, c, 0, 0, 0);
            else if (sel < 95)
                send(OP_READ, a, 0, 0, 0, 0, 0);
            else
                send(OP_NONE, int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom), int'($urandom));
        end

        // accumulator saturation on one fixed triangle, no idling from here on
        quiet = 1'b1;
        send(OP_LOAD, 100, 0, 0, 0, 0, 0);
        send(OP_LOAD, 101, 0, 0, 1 << 16, 0, 0);
        send(OP_LOAD, 102, 0, 0, 0, 0, 1 << 16);
        for (int i = 0; i < 520; i++)
        begin
            send(OP_TRI, 100, 101, 102, 0, 0, 0);
            if (i % 100 == 0)
                send(OP_READ, 101, 0, 0, 0, 0, 0);
        end
        send(OP_READ, 100, 0, 0, 0, 0, 0);
        send(OP_READ, 102, 0, 0, 0, 0, 0);
        item_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d loads, %0d triangles, %0d reads checked", load_count,
                 tri_count, read_count);
        $display("extreme coordinates, degenerate faces, repeated corners and saturation");
        if (fail_count == 0)
            $display("mesh_vertex_normal_accumulator verification clean");
        else
            $display("mesh_vertex_normal_accumulator verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/mvna_pkg.sv
src/mvna_ctrl.sv
src/mvna_dp.sv
src/mesh_vertex_normal_accumulator.sv
dv/mvna_checker.sv
dv/mesh_vertex_normal_accumulator_tb.sv
